// ===== rtl/fjfk_pkg.sv =====
// ----------------------------------------------------------------------------
// fjfk_pkg: shared types and constants
// Widths, CORDIC arctangent table and register indexes for the arm core.
// ----------------------------------------------------------------------------
package fjfk_pkg;

  localparam int AngW    = 16;
  localparam int LinkW   = 16;
  localparam int OutW    = 19;
  localparam int Iters   = 16;
  localparam int CordW   = 34;   // x/y datapath, signed
  localparam int ZW      = 32;   // residual angle, signed
  localparam int TrigW   = 32;   // clamped Q2.30 result, signed
  localparam int ProdW   = 50;   // link * trig
  localparam int SumW    = 52;
  localparam int RegIdxW = 2;

  localparam logic signed [CordW-1:0] CordStart = 34'sd652032875;
  localparam logic signed [TrigW-1:0] OneQ30    = 32'sd1073741824;
  localparam logic [LinkW-1:0]        LinkReset = 16'd2560;

  typedef enum logic [RegIdxW-1:0] {
    REG_BASE_HEIGHT = 2'd0,
    REG_UPPER_LINK  = 2'd1,
    REG_FORE_LINK   = 2'd2,
    REG_TOOL_LINK   = 2'd3
  } reg_idx_t;

  // One CORDIC lane: vector, residual angle and quadrant.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic [1:0]              quad;
  } lane_t;

  function automatic logic signed [ZW-1:0] atan_of(input logic [3:0] i);
    case (i)
      4'd0:    atan_of = 32'sh20000000;
      4'd1:    atan_of = 32'sh12E4051D;
      4'd2:    atan_of = 32'sh09FB385B;
      4'd3:    atan_of = 32'sh051111D4;
      4'd4:    atan_of = 32'sh028B0D43;
      4'd5:    atan_of = 32'sh0145D7E1;
      4'd6:    atan_of = 32'sh00A2F61E;
      4'd7:    atan_of = 32'sh00517C55;
      4'd8:    atan_of = 32'sh0028BE53;
      4'd9:    atan_of = 32'sh00145F2E;
      4'd10:   atan_of = 32'sh000A2F98;
      4'd11:   atan_of = 32'sh000517CC;
      4'd12:   atan_of = 32'sh00028BE6;
      4'd13:   atan_of = 32'sh000145F3;
      4'd14:   atan_of = 32'sh0000A2F9;
      default: atan_of = 32'sh0000517C;
    endcase
  endfunction

endpackage

// ===== rtl/fjfk_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// fjfk_cordic_cell: one micro-rotation of four CORDIC lanes
// Rotates each lane by +/- atan(2^-Shift) and hands it to the next cell.
// ----------------------------------------------------------------------------
module fjfk_cordic_cell
  import fjfk_pkg::*;
#(
  parameter int Shift = 0
) (
  input  logic        clk,
  input  logic        adv,
  input  lane_t [3:0] lane_in,
  output lane_t [3:0] lane_out
);

  localparam logic signed [ZW-1:0] Atan = atan_of(4'(Shift));

  lane_t [3:0] lane_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_next[k].quad = lane_in[k].quad;
      if (lane_in[k].z >= 0) begin
        lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> Shift);
        lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> Shift);
        lane_next[k].z = lane_in[k].z - Atan;
      end else begin
        lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> Shift);
        lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> Shift);
        lane_next[k].z = lane_in[k].z + Atan;
      end
    end
  end

  // Payload only; hold while the pipe is stalled.
  always_ff @(posedge clk) begin
    if (adv) lane_out <= lane_next;
  end

endmodule

// ===== rtl/fjfk_arm_math.sv =====
// ----------------------------------------------------------------------------
// fjfk_arm_math: link products and position sums
// Folds quadrants, forms reach and z, then x and y, over four stages.
// ----------------------------------------------------------------------------
module fjfk_arm_math
  import fjfk_pkg::*;
(
  input  logic                    clk,
  input  logic [3:0]              adv,
  input  lane_t [3:0]             lane_in,
  input  logic [LinkW-1:0]        l1,
  input  logic [LinkW-1:0]        l2,
  input  logic [LinkW-1:0]        l3,
  input  logic [LinkW-1:0]        l4,
  output logic signed [OutW-1:0]  x_out,
  output logic signed [OutW-1:0]  y_out,
  output logic signed [OutW-1:0]  z_out
);

  logic signed [TrigW-1:0] c_next [4];
  logic signed [TrigW-1:0] s_next [4];
  logic signed [TrigW-1:0] cq [4];
  logic signed [TrigW-1:0] sq [4];

  function automatic logic signed [TrigW-1:0] clampu(input logic signed [CordW:0] v);
    if (v > CordW'(OneQ30)) clampu = OneQ30;
    else if (v < -(CordW+1)'(OneQ30)) clampu = -OneQ30;
    else clampu = TrigW'(v);
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (lane_in[k].quad)
        2'd0: begin
          c_next[k] = clampu((CordW+1)'(lane_in[k].x));
          s_next[k] = clampu((CordW+1)'(lane_in[k].y));
        end
        2'd1: begin
          c_next[k] = clampu(-(CordW+1)'(lane_in[k].y));
          s_next[k] = clampu((CordW+1)'(lane_in[k].x));
        end
        2'd2: begin
          c_next[k] = clampu(-(CordW+1)'(lane_in[k].x));
          s_next[k] = clampu(-(CordW+1)'(lane_in[k].y));
        end
        default: begin
          c_next[k] = clampu((CordW+1)'(lane_in[k].y));
          s_next[k] = clampu(-(CordW+1)'(lane_in[k].x));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < 4; k++) begin
        cq[k] <= c_next[k];
        sq[k] <= s_next[k];
      end
    end
  end

  // Stage 1: six link products, registered.
  logic signed [ProdW-1:0] pc2, pc3, pc4, ps2, ps3, ps4;
  logic signed [TrigW-1:0] c1_d, s1_d;
  logic [LinkW-1:0]        l1_d;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pc2  <= $signed({1'b0, l2}) * cq[1];
      pc3  <= $signed({1'b0, l3}) * cq[2];
      pc4  <= $signed({1'b0, l4}) * cq[3];
      ps2  <= $signed({1'b0, l2}) * sq[1];
      ps3  <= $signed({1'b0, l3}) * sq[2];
      ps4  <= $signed({1'b0, l4}) * sq[3];
      c1_d <= cq[0];
      s1_d <= sq[0];
      l1_d <= l1;
    end
  end

  // Stage 2: sums and rounding to Q.8.
  logic signed [SumW-1:0]   rsum, zsum;
  logic signed [SumW-31:0]  reach;
  logic signed [TrigW-1:0]  c1_e, s1_e;
  logic signed [OutW-1:0]   z_d;

  always_comb begin
    rsum = SumW'(pc2) + SumW'(pc3) + SumW'(pc4) + SumW'(64'sd1 <<< 29);
    zsum = $signed({2'b0, l1_d, 34'b0} >> 4) + SumW'(ps2) + SumW'(ps3)
         + SumW'(ps4) + SumW'(64'sd1 <<< 29);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      reach <= rsum[SumW-1:30];
      z_d   <= OutW'(zsum >>> 30);
      c1_e  <= c1_d;
      s1_e  <= s1_d;
    end
  end

  // Stage 3: reach times yaw cosine and sine; z moves along with x and y.
  logic signed [SumW-1:0] xs, ys;
  always_comb begin
    xs = SumW'(reach) * SumW'(c1_e) + SumW'(64'sd1 <<< 29);
    ys = SumW'(reach) * SumW'(s1_e) + SumW'(64'sd1 <<< 29);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      x_out <= OutW'(xs >>> 30);
      y_out <= OutW'(ys >>> 30);
      z_out <= z_d;
    end
  end

endmodule

// ===== rtl/four_joint_arm_forward_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// four_joint_arm_forward_kinematics_core: tool tip position of a 4-joint arm
// Base yaw plus three pitch joints; CORDIC cell chain and link arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one beat carries yaw, shoulder, elbow
//   and wrist angles in binary angle units (65536 = one turn).
//   Output channel (out_valid/out_stall): one beat carries tip_x/y/z, signed
//   Q11.8. Every input beat gives exactly one output beat, in order.
//   Config channel (cfg_valid/cfg_ready): index 0..3 selects base height,
//   upper, fore and tool link (unsigned Q8.8). The 2-bit index has no others.
//   Write only while no beat is in flight.
// Pipeline: 21 register stages (1 input stage, 16 CORDIC cells, 1 fold stage,
//   product, sum and yaw product stages, the last being the output).
// Throughput: one beat per cycle while the output is not stalled; set by the
//   chain of CORDIC cells, each handing on four lanes whenever the pipe moves.
// Stall: the pipe is an elastic chain; a stage loads when it is empty or its
//   beat moves on, so bubbles are squeezed out and a held output still lets
//   earlier stages fill. in_stall rises only when the whole chain is full.
// Reset: clears all valid bits and sets every link to 10.0.
// ----------------------------------------------------------------------------
module four_joint_arm_forward_kinematics_core
  import fjfk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [AngW-1:0]        yaw_angle,
  input  logic [AngW-1:0]        shoulder_angle,
  input  logic [AngW-1:0]        elbow_angle,
  input  logic [AngW-1:0]        wrist_angle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OutW-1:0] tip_x,
  output logic signed [OutW-1:0] tip_y,
  output logic signed [OutW-1:0] tip_z,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [RegIdxW-1:0]     cfg_index,
  input  logic [LinkW-1:0]       cfg_data
);

  localparam int Stages = Iters + 5;

  // Valid bit per stage; stage Stages-1 is the output register.
  logic [Stages-1:0] vld;
  logic [Stages-1:0] adv;

  // Load a stage when it is empty or its beat moves on.
  always_comb begin
    adv[Stages-1] = !vld[Stages-1] || !out_stall;
    for (int i = Stages-2; i >= 0; i--) adv[i] = !vld[i] || adv[i+1];
  end

  assign in_stall  = !adv[0] && vld[0];
  assign out_valid = vld[Stages-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
        else if (adv[i-1]) vld[i] <= vld[i];
      end
    end
  end

  logic [LinkW-1:0] l1, l2, l3, l4;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= LinkReset;
      l2 <= LinkReset;
      l3 <= LinkReset;
      l4 <= LinkReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_HEIGHT: l1 <= cfg_data;
        REG_UPPER_LINK:  l2 <= cfg_data;
        REG_FORE_LINK:   l3 <= cfg_data;
        REG_TOOL_LINK:   l4 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: angle sums, quadrant split, seed the four lanes.
  logic [AngW-1:0] ang [4];
  lane_t [3:0]     seed;
  lane_t [3:0]     chain [Iters+1];

  always_comb begin
    ang[0] = yaw_angle;
    ang[1] = shoulder_angle;
    ang[2] = shoulder_angle + elbow_angle;
    ang[3] = ang[2] + wrist_angle;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < 4; k++) begin
        logic [AngW-1:0] t;
        t = ang[k] + 16'h2000;
        seed[k].quad <= t[15:14];
        seed[k].z    <= ZW'($signed({1'b0, t[13:0]}) - 16'sh2000) <<< 16;
        seed[k].x    <= CordStart;
        seed[k].y    <= '0;
      end
    end
  end

  assign chain[0] = seed;

  for (genvar g = 0; g < Iters; g++) begin : g_cell
    fjfk_cordic_cell #(.Shift(g)) u_cell (
      .clk      (clk),
      .adv      (adv[g+1]),
      .lane_in  (chain[g]),
      .lane_out (chain[g+1])
    );
  end

  fjfk_arm_math u_math (
    .clk     (clk),
    .adv     (adv[Iters+4:Iters+1]),
    .lane_in (chain[Iters]),
    .l1      (l1),
    .l2      (l2),
    .l3      (l3),
    .l4      (l4),
    .x_out   (tip_x),
    .y_out   (tip_y),
    .z_out   (tip_z)
  );

  // Stage Stages-1 is the x/y/z output register inside the math unit; z is
  // formed one stage earlier and passes through that register to stay aligned.

  // A held output beat keeps its valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped under stall");

  // Input is refused only when the first stage is full and blocked.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0] && out_stall)
    else $error("input stalled while pipe could move");

  // Nothing appears at the output without a beat entering earlier.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[Stages-2]))
    else $error("output beat without source");

endmodule
